>>> src/qrbm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrbm_pkg
// Types and constants shared by the quartic ring base multiplier.
// ----------------------------------------------------------------------------
package qrbm_pkg;

	// Default modulus q of the coefficient ring.
	localparam int QRBM_MODULUS = 3457;

	// Montgomery constant q^-1 mod 2^16.
	localparam int QINV_MONT = 12929;

	// Rounded Barrett centring: k = (v * MUL + ROUND) >> SHIFT.
	localparam int BARRETT_MUL   = 10;
	localparam int BARRETT_ROUND = 16384;
	localparam int BARRETT_SHIFT = 15;

	// Input item: both operands and the ring twiddle.
	typedef struct packed {
		logic signed [15:0] a_coef0;
		logic signed [15:0] a_coef1;
		logic signed [15:0] a_coef2;
		logic signed [15:0] a_coef3;
		logic signed [15:0] b_coef0;
		logic signed [15:0] b_coef1;
		logic signed [15:0] b_coef2;
		logic signed [15:0] b_coef3;
		logic signed [15:0] twiddle;
	} in_item_t;

	// Result item: centred product coefficients.
	typedef struct packed {
		logic signed [15:0] c_coef0;
		logic signed [15:0] c_coef1;
		logic signed [15:0] c_coef2;
		logic signed [15:0] c_coef3;
	} out_item_t;

	// Load enables of the pipeline stages inside one Montgomery unit.
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
	} mont_en_t;

endpackage

>>> src/quartic_ring_basemul_montgomery.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quartic_ring_basemul_montgomery
// Base multiplication in Z_q[x]/(x^4 - lambda) with Montgomery reduction
// and rounded Barrett centring of each result coefficient.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle while out_ready is high; the ten-stage
// pipeline advances each stage whenever the stage after it has room.
// Reset clears the stage valid bits only; the datapath registers have no reset.
// ----------------------------------------------------------------------------
module quartic_ring_basemul_montgomery #(
	parameter int MODULUS = qrbm_pkg::QRBM_MODULUS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  qrbm_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output qrbm_pkg::out_item_t out_item
);
	import qrbm_pkg::*;

	localparam int NST = 10;
	localparam int QW  = $clog2(MODULUS + 1);
	localparam logic signed [QW:0] QS = (QW + 1)'(MODULUS);
	localparam int KW = 24 - BARRETT_SHIFT;

	logic [NST:1]   vld_q;
	logic [NST+1:1] en;

	logic signed [15:0] a [4];
	logic signed [15:0] b [4];
	logic signed [15:0] r [4][4];
	logic signed [15:0] mw [3];

	logic signed [15:0] lam_s1, lam_s2, lam_s3, lam_s4;
	logic signed [15:0] w_s4 [3];
	logic signed [18:0] d_s4 [4];
	logic signed [18:0] d_s5 [4];
	logic signed [18:0] d_s6 [4];
	logic signed [18:0] d_s7 [4];
	logic signed [18:0] v_s8 [4];
	logic signed [18:0] v_s9 [4];
	logic signed [KW-1:0] k_s9 [4];
	logic signed [15:0] c_s10 [4];
	logic signed [23:0] bsum [4];
	logic signed [KW+QW:0] kq [4];

	mont_en_t en_a;
	mont_en_t en_b;

	// Stage enables: a stage loads when it is empty or its item moves on.
	always_comb begin
		en[NST+1] = out_ready;
		for (int k = NST; k >= 1; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	assign in_ready = en[1];

	// Valid bits travel with the items.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[1]) begin
				vld_q[1] <= in_valid;
			end
			for (int k = 2; k <= NST; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	// Operand unpacking.
	always_comb begin
		a[0] = in_item.a_coef0;
		a[1] = in_item.a_coef1;
		a[2] = in_item.a_coef2;
		a[3] = in_item.a_coef3;
		b[0] = in_item.b_coef0;
		b[1] = in_item.b_coef1;
		b[2] = in_item.b_coef2;
		b[3] = in_item.b_coef3;
	end

	// Stages 1 to 3: all sixteen coefficient products, Montgomery reduced.
	assign en_a = '{s1: en[1], s2: en[2], s3: en[3]};

	for (genvar gi = 0; gi < 4; gi++) begin : g_row
		for (genvar gj = 0; gj < 4; gj++) begin : g_col
			qrbm_mont #(
				.MODULUS(MODULUS)
			) u_mont (
				.clk(clk),
				.en (en_a),
				.x  (a[gi]),
				.y  (b[gj]),
				.r  (r[gi][gj])
			);
		end
	end

	// Twiddle follows the products up to the lambda multiply.
	always_ff @(posedge clk) begin
		if (en[1]) begin
			lam_s1 <= in_item.twiddle;
		end
		if (en[2]) begin
			lam_s2 <= lam_s1;
		end
		if (en[3]) begin
			lam_s3 <= lam_s2;
		end
		if (en[4]) begin
			lam_s4 <= lam_s3;
		end
	end

	// Stage 4: wrapped-around sums cut to 16 bits, direct sums in full width.
	always_ff @(posedge clk) begin
		if (en[4]) begin
			w_s4[0] <= r[1][3] + r[2][2] + r[3][1];
			w_s4[1] <= r[2][3] + r[3][2];
			w_s4[2] <= r[3][3];
			d_s4[0] <= 19'(r[0][0]);
			d_s4[1] <= 19'(r[0][1]) + 19'(r[1][0]);
			d_s4[2] <= 19'(r[0][2]) + 19'(r[1][1]) + 19'(r[2][0]);
			d_s4[3] <= 19'(r[0][3]) + 19'(r[1][2]) + 19'(r[2][1]) + 19'(r[3][0]);
		end
	end

	// Stages 5 to 7: wrapped-around sums times lambda.
	assign en_b = '{s1: en[5], s2: en[6], s3: en[7]};

	for (genvar gk = 0; gk < 3; gk++) begin : g_lam
		qrbm_mont #(
			.MODULUS(MODULUS)
		) u_mont (
			.clk(clk),
			.en (en_b),
			.x  (w_s4[gk]),
			.y  (lam_s4),
			.r  (mw[gk])
		);
	end

	// Direct sums wait alongside the lambda multiply.
	always_ff @(posedge clk) begin
		if (en[5]) begin
			d_s5 <= d_s4;
		end
		if (en[6]) begin
			d_s6 <= d_s5;
		end
		if (en[7]) begin
			d_s7 <= d_s6;
		end
	end

	// Stage 8: full-width coefficient sums.
	always_ff @(posedge clk) begin
		if (en[8]) begin
			for (int i = 0; i < 3; i++) begin
				v_s8[i] <= d_s7[i] + 19'(mw[i]);
			end
			v_s8[3] <= d_s7[3];
		end
	end

	// Stage 9: Barrett quotient estimate, rounded.
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			bsum[i] = 24'(v_s8[i]) * 24'(BARRETT_MUL) + 24'(BARRETT_ROUND);
		end
	end

	always_ff @(posedge clk) begin
		if (en[9]) begin
			for (int i = 0; i < 4; i++) begin
				v_s9[i] <= v_s8[i];
				k_s9[i] <= bsum[i][23:BARRETT_SHIFT];
			end
		end
	end

	// Stage 10: subtract k * q; the result wraps to 16 bits.
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			kq[i] = k_s9[i] * QS;
		end
	end

	always_ff @(posedge clk) begin
		if (en[10]) begin
			for (int i = 0; i < 4; i++) begin
				c_s10[i] <= v_s9[i][15:0] - kq[i][15:0];
			end
		end
	end

	// Output item.
	assign out_valid        = vld_q[NST];
	assign out_item.c_coef0 = c_s10[0];
	assign out_item.c_coef1 = c_s10[1];
	assign out_item.c_coef2 = c_s10[2];
	assign out_item.c_coef3 = c_s10[3];

endmodule

>>> src/qrbm_mont.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrbm_mont
// Three-stage signed 16-bit Montgomery multiplier: r = x * y * 2^-16 mod q.
// ----------------------------------------------------------------------------
module qrbm_mont #(
	parameter int MODULUS = qrbm_pkg::QRBM_MODULUS
) (
	input  logic               clk,
	input  qrbm_pkg::mont_en_t en,
	input  logic signed [15:0] x,
	input  logic signed [15:0] y,
	output logic signed [15:0] r
);
	import qrbm_pkg::*;

	localparam int QW = $clog2(MODULUS + 1);
	localparam logic signed [QW:0] QS = (QW + 1)'(MODULUS);

	logic signed [31:0] t_s1;
	logic signed [15:0] hi_s2;
	logic signed [15:0] u_s2;
	logic signed [15:0] r_s3;
	logic        [31:0] uprod;
	logic signed [31:0] mprod;

	// Stage 1: full product.
	always_ff @(posedge clk) begin
		if (en.s1) begin
			t_s1 <= x * y;
		end
	end

	// Stage 2: low half times q^-1, keep the high half of the product.
	assign uprod = t_s1[15:0] * 16'(QINV_MONT);

	always_ff @(posedge clk) begin
		if (en.s2) begin
			u_s2  <= signed'(uprod[15:0]);
			hi_s2 <= t_s1[31:16];
		end
	end

	// Stage 3: subtract the high half of u * q; the result wraps to 16 bits.
	assign mprod = u_s2 * QS;

	always_ff @(posedge clk) begin
		if (en.s3) begin
			r_s3 <= hi_s2 - mprod[31:16];
		end
	end

	assign r = r_s3;

endmodule
